[rtl/complex_arithmetic_unit_assert.svh]
// Assertion macros used by the complex arithmetic unit top level.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked on i_clk, off while reset is held.
`define CAU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("complex_arithmetic_unit: check failed");

// Implication with a fixed delay in cycles.
`define CAU_ASSERT_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("complex_arithmetic_unit: latency check failed");

`endif

[rtl/cau_pkg.sv]
// Types and constants of the complex arithmetic unit.
`default_nettype none
package cau_pkg;

    localparam int IN_W       = 16;              // field width
    localparam int OPND_W     = IN_W + 1;        // operand after extraction
    localparam int PROD_W     = 2 * OPND_W;      // one product
    localparam int SUM_W      = PROD_W + 1;      // sum of two products
    localparam int MAG_W      = 33;              // |sum of products| bound
    localparam int FRAC_SHIFT = 16;              // quotient pre-scale
    localparam int ADD_SHIFT  = 8;               // Q8.8 -> Q16.16
    localparam int NUM_W      = MAG_W + FRAC_SHIFT;
    localparam int DEN_W      = 33;              // br^2 + bi^2 bound
    localparam int DIV_CELLS  = NUM_W;           // one quotient bit per cell
    localparam int QS_W       = NUM_W + 1;       // signed quotient
    localparam int RES_W      = 32;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [IN_W-1:0]   a_real;
        logic signed [IN_W-1:0]   a_imag;
        logic signed [IN_W-1:0]   b_real;
        logic signed [IN_W-1:0]   b_imag;
    } t_cau_in;

    typedef struct packed {
        logic signed [RES_W-1:0]  res_real;
        logic signed [RES_W-1:0]  res_imag;
        logic                     div_zero;
        logic                     overflow;
    } t_cau_out;

    // One divide lane: partial remainder plus numerator bits shifting out
    // at the top while quotient bits shift in at the bottom.
    typedef struct packed {
        logic                     neg;
        logic [DEN_W-1:0]         rem;
        logic [NUM_W-1:0]         nq;
    } t_cau_lane;

    typedef struct packed {
        logic                     valid;
        logic                     is_div;
        logic                     dz;
        logic [DEN_W-1:0]         den;
        t_cau_lane                re;
        t_cau_lane                im;
        logic signed [SUM_W-1:0]  dre;   // add/sub/mul result
        logic signed [SUM_W-1:0]  dim;
    } t_cau_stage;

endpackage
`default_nettype wire

[rtl/cau_div_cell.sv]
// One restoring-division cell: resolves one quotient bit of both lanes.
`default_nettype none
module cau_div_cell
    import cau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cau_stage i_stage,
    output t_cau_stage o_stage
);

    function automatic t_cau_lane div_step(input t_cau_lane l, input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        t_cau_lane      r;
        t     = {l.rem, l.nq[NUM_W-1]};
        d     = {1'b0, den};
        r.neg = l.neg;
        if (t >= d) begin
            t    = t - d;
            r.nq = {l.nq[NUM_W-2:0], 1'b1};
        end else begin
            r.nq = {l.nq[NUM_W-2:0], 1'b0};
        end
        r.rem = t[DEN_W-1:0];
        return r;
    endfunction

    t_cau_stage r_stage;
    t_cau_stage n_stage;

    always_comb begin
        n_stage    = i_stage;
        n_stage.re = div_step(i_stage.re, i_stage.den);
        n_stage.im = div_step(i_stage.im, i_stage.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule
`default_nettype wire

[rtl/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: operand prep, divider chain, saturation.
//
// Usage:
//  - Input channel: drive i_item (cmd, a_real, a_imag, b_real, b_imag, Q8.8)
//    and raise start; the beat is taken at a clock edge with start high and
//    busy low. busy is high only while reset is held and for the cycle
//    after it, so a new beat can go in every cycle.
//  - Output channel: o_res (res_real, res_imag in Q16.16, div_zero,
//    overflow) is valid for exactly one cycle while o_strobe is high. The
//    receiver cannot stall; it must take each beat as it appears.
//  - Every opcode takes the same path from the accepting edge: operand
//    extraction, products, sums, the divider chain and the output register.
//    Throughput is one beat per cycle. The divider is a chain of 49 cells,
//    each resolving one quotient bit of the real and imaginary lanes.
//  - Add/sub/mul results ride along the same chain so results leave in
//    order. A zero divisor gives zero parts with div_zero set.
//  - Reset (i_rst_n low, synchronous) drops every beat in flight.
`default_nettype none
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int COMP_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_cau_in  i_item,
    output logic     o_strobe,
    output t_cau_out o_res
);

`include "complex_arithmetic_unit_assert.svh"

    localparam int SIGN_BIT = (COMP_BITS > IN_W) ? IN_W - 1 : COMP_BITS - 1;
    localparam int LAT      = 4 + DIV_CELLS;
    localparam logic signed [QS_W-1:0] SAT_HI = {{(QS_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
    localparam logic signed [QS_W-1:0] SAT_LO = {{(QS_W-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}};

    // Low COMP_BITS of the field, sign extended; wider settings read unsigned.
    function automatic logic signed [OPND_W-1:0] part_of(input logic [IN_W-1:0] f);
        logic signed [OPND_W-1:0] v;
        for (int k = 0; k < OPND_W; k++) begin
            if (k < IN_W && k < COMP_BITS) begin
                v[k] = f[k];
            end else if (COMP_BITS > IN_W) begin
                v[k] = 1'b0;
            end else begin
                v[k] = f[SIGN_BIT];
            end
        end
        return v;
    endfunction

    // Saturate a wide value to 32 bits; flag in bit 0 of the return.
    function automatic logic [RES_W:0] sat32(input logic signed [QS_W-1:0] x);
        logic [RES_W:0] r;
        if (x > SAT_HI) begin
            r = {SAT_HI[RES_W-1:0], 1'b1};
        end else if (x < SAT_LO) begin
            r = {SAT_LO[RES_W-1:0], 1'b1};
        end else begin
            r = {x[RES_W-1:0], 1'b0};
        end
        return r;
    endfunction

    // ---- reset release: busy until the first cycle after reset ----
    logic r_rdy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end
    assign busy = !r_rdy;

    logic accept;
    assign accept = start && !busy;

    // ---- stage A: operand extraction ----
    logic                     r_a_vld;
    logic [1:0]               r_a_cmd;
    logic signed [OPND_W-1:0] r_ar, r_ai, r_br, r_bi;

    always_ff @(posedge i_clk) begin
        r_a_cmd <= i_item.cmd;
        r_ar    <= part_of(i_item.a_real);
        r_ai    <= part_of(i_item.a_imag);
        r_br    <= part_of(i_item.b_real);
        r_bi    <= part_of(i_item.b_imag);
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
        end
    end

    // ---- stage B: six parallel products and the add/sub results ----
    logic                     r_b_vld;
    logic [1:0]               r_b_cmd;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_r, r_sq_i;
    logic signed [SUM_W-1:0]  r_as_re, r_as_im;
    logic signed [SUM_W-1:0]  n_as_re, n_as_im;

    always_comb begin
        if (r_a_cmd == CMD_SUB) begin
            n_as_re = (SUM_W'(r_ar) - SUM_W'(r_br)) <<< ADD_SHIFT;
            n_as_im = (SUM_W'(r_ai) - SUM_W'(r_bi)) <<< ADD_SHIFT;
        end else begin
            n_as_re = (SUM_W'(r_ar) + SUM_W'(r_br)) <<< ADD_SHIFT;
            n_as_im = (SUM_W'(r_ai) + SUM_W'(r_bi)) <<< ADD_SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_cmd <= r_a_cmd;
        r_p_rr  <= r_ar * r_br;
        r_p_ii  <= r_ai * r_bi;
        r_p_ri  <= r_ar * r_bi;
        r_p_ir  <= r_ai * r_br;
        r_sq_r  <= r_br * r_br;
        r_sq_i  <= r_bi * r_bi;
        r_as_re <= n_as_re;
        r_as_im <= n_as_im;
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    // ---- stage C: sums of products, divider lane setup ----
    t_cau_stage               n_c;
    t_cau_stage               r_c;
    logic signed [SUM_W-1:0]  num_re, num_im, mag_re, mag_im;

    always_comb begin
        num_re       = SUM_W'(r_p_rr) + SUM_W'(r_p_ii);
        num_im       = SUM_W'(r_p_ir) - SUM_W'(r_p_ri);
        mag_re       = num_re[SUM_W-1] ? -num_re : num_re;
        mag_im       = num_im[SUM_W-1] ? -num_im : num_im;
        n_c.valid    = r_b_vld;
        n_c.is_div   = (r_b_cmd == CMD_DIV);
        n_c.den      = {1'b0, r_sq_r[RES_W-1:0]} + {1'b0, r_sq_i[RES_W-1:0]};
        n_c.dz       = n_c.is_div && (n_c.den == '0);
        n_c.re.neg   = num_re[SUM_W-1];
        n_c.re.rem   = '0;
        n_c.re.nq    = {mag_re[MAG_W-1:0], {FRAC_SHIFT{1'b0}}};
        n_c.im.neg   = num_im[SUM_W-1];
        n_c.im.rem   = '0;
        n_c.im.nq    = {mag_im[MAG_W-1:0], {FRAC_SHIFT{1'b0}}};
        if (r_b_cmd == CMD_MUL) begin
            n_c.dre = SUM_W'(r_p_rr) - SUM_W'(r_p_ii);
            n_c.dim = SUM_W'(r_p_ri) + SUM_W'(r_p_ir);
        end else begin
            n_c.dre = r_as_re;
            n_c.dim = r_as_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else begin
            r_c <= n_c;
        end
    end

    // ---- divider chain ----
    t_cau_stage chain [DIV_CELLS+1];
    assign chain[0] = r_c;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    // ---- output: sign, select, saturate ----
    t_cau_stage               tail;
    logic signed [QS_W-1:0]   v_re, v_im;
    logic [RES_W:0]           s_re, s_im;
    t_cau_out                 n_res;
    t_cau_out                 r_res;
    logic                     r_strobe;

    assign tail = chain[DIV_CELLS];

    always_comb begin
        if (tail.is_div) begin
            if (tail.dz) begin
                v_re = '0;
                v_im = '0;
            end else begin
                v_re = tail.re.neg ? -$signed({1'b0, tail.re.nq}) : $signed({1'b0, tail.re.nq});
                v_im = tail.im.neg ? -$signed({1'b0, tail.im.nq}) : $signed({1'b0, tail.im.nq});
            end
        end else begin
            v_re = QS_W'(tail.dre);
            v_im = QS_W'(tail.dim);
        end
        s_re           = sat32(v_re);
        s_im           = sat32(v_im);
        n_res.res_real = s_re[RES_W:1];
        n_res.res_imag = s_im[RES_W:1];
        n_res.div_zero = tail.dz;
        n_res.overflow = s_re[0] || s_im[0];
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= tail.valid;
        end
    end

    assign o_res    = r_res;
    assign o_strobe = r_strobe;

    // ---- checks ----
    logic res_zero;
    logic re_rail;
    logic im_rail;
    assign res_zero = (o_res.res_real == '0) && (o_res.res_imag == '0);
    assign re_rail  = (o_res.res_real == SAT_HI[RES_W-1:0])
                   || (o_res.res_real == SAT_LO[RES_W-1:0]);
    assign im_rail  = (o_res.res_imag == SAT_HI[RES_W-1:0])
                   || (o_res.res_imag == SAT_LO[RES_W-1:0]);

    `CAU_ASSERT_IMPL(a_dz_no_ovf, o_strobe && o_res.div_zero, !o_res.overflow)
    `CAU_ASSERT_IMPL(a_dz_zero, o_strobe && o_res.div_zero, res_zero)
    `CAU_ASSERT_IMPL(a_ovf_rail, o_strobe && o_res.overflow, re_rail || im_rail)
    `CAU_ASSERT_DELAY(a_latency, accept, LAT, o_strobe)

endmodule
`default_nettype wire
